// ----- hdl/wrta_pkg.sv -----
// ----------------------------------------------------------------------------
// wrta_pkg
// Shared types and codes of the request table with aging.
// ----------------------------------------------------------------------------
package wrta_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [15:0] service;
    logic [15:0] subtype;
    logic [31:0] request;
    logic [31:0] payload;
    logic [31:0] stamp;
  } entry_t;

endpackage

// ----- hdl/wildcard_request_table_with_aging_unit.sv -----
// ----------------------------------------------------------------------------
// wildcard_request_table_with_aging_unit
// Ordered request table with wildcard find-and-remove and age-based expiry.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Add and the unused
// command code finish at once: the result appears on the cycle after start
// and busy stays low. Find and expire walk the table, oldest entry first,
// one entry memory read per cycle through a single compare unit, compacting
// kept entries in place. They hold busy high while the walk runs, and the
// result follows in the next cycle with busy low. Each result is shown for
// exactly one cycle with done high; the receiver cannot stall it, so it must
// capture every done cycle.
// ----------------------------------------------------------------------------
module wildcard_request_table_with_aging_unit #(
  parameter int TABLE_DEPTH = wrta_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [15:0] service_key,
  input  logic [15:0] subtype_key,
  input  logic [31:0] request_key,
  input  logic [31:0] payload_in,
  input  logic [31:0] now_seconds,
  input  logic [31:0] max_age,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] service_out,
  output logic [15:0] subtype_out,
  output logic [31:0] request_out,
  output logic [31:0] payload_out,
  output logic [4:0]  removed_count,
  output logic [4:0]  occupancy
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] wr_idx;
  logic [CNT_W-1:0] removed;
  logic             ev_valid;
  logic             hit;

  logic             find_mode;
  logic [15:0]      skey;
  logic [15:0]      tkey;
  logic [31:0]      rkey;
  logic [31:0]      now_q;
  logic [31:0]      maxage_q;

  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  wrta_pkg::entry_t mem_wdata;
  wrta_pkg::entry_t mem_rdata;
  logic             issue;
  logic             drop;
  logic             full;

  assign busy  = (state != S_IDLE);
  assign issue = (rd_idx != count);
  assign full  = (count == CNT_W'(TABLE_DEPTH));

  wrta_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  wrta_match u_match (
    .entry       (mem_rdata),
    .find_mode   (find_mode),
    .already_hit (hit),
    .service_key (skey),
    .subtype_key (tkey),
    .request_key (rkey),
    .now_seconds (now_q),
    .max_age     (maxage_q),
    .drop        (drop)
  );

  // write port: append on add, compaction of kept entries during a scan
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[ADDR_W-1:0];
    mem_wdata = '{service: service_key, subtype: subtype_key, request: request_key,
                  payload: payload_in, stamp: now_seconds};
    case (state)
      S_IDLE: begin
        mem_we = start && (command == wrta_pkg::CMD_ADD) && !full;
      end
      S_SCAN: begin
        mem_we    = ev_valid && !drop;
        mem_waddr = wr_idx[ADDR_W-1:0];
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      count    <= '0;
      ev_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            find_mode     <= (command == wrta_pkg::CMD_FIND);
            skey          <= service_key;
            tkey          <= subtype_key;
            rkey          <= request_key;
            now_q         <= now_seconds;
            maxage_q      <= max_age;
            rd_idx        <= '0;
            wr_idx        <= '0;
            removed       <= '0;
            hit           <= 1'b0;
            ev_valid      <= 1'b0;
            service_out   <= '0;
            subtype_out   <= '0;
            request_out   <= '0;
            payload_out   <= '0;
            removed_count <= '0;
            status        <= wrta_pkg::ST_OK;
            occupancy     <= 5'(count);
            case (command)
              wrta_pkg::CMD_ADD: begin
                done <= 1'b1;
                if (full) begin
                  status <= wrta_pkg::ST_FULL;
                end else begin
                  count     <= count + 1'b1;
                  occupancy <= 5'(count + 1'b1);
                end
              end
              wrta_pkg::CMD_FIND, wrta_pkg::CMD_EXPIRE: begin
                state <= S_SCAN;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // read of rd_idx issued now; evaluation of the previous read
          ev_valid <= issue;
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (ev_valid) begin
            if (drop) begin
              removed <= removed + 1'b1;
              if (find_mode) begin
                hit         <= 1'b1;
                service_out <= mem_rdata.service;
                subtype_out <= mem_rdata.subtype;
                request_out <= mem_rdata.request;
                payload_out <= mem_rdata.payload;
              end
            end else begin
              wr_idx <= wr_idx + 1'b1;
            end
          end else if (!issue) begin
            done          <= 1'b1;
            status        <= (find_mode && !hit) ? wrta_pkg::ST_MISS : wrta_pkg::ST_OK;
            removed_count <= 5'(removed);
            occupancy     <= 5'(wr_idx);
            count         <= wr_idx;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/wrta_store.sv -----
// ----------------------------------------------------------------------------
// wrta_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wrta_store #(
  parameter int TABLE_DEPTH = wrta_pkg::TABLE_DEPTH_DEFAULT,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  wrta_pkg::entry_t    wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output wrta_pkg::entry_t    rdata
);

  wrta_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/wrta_match.sv -----
// ----------------------------------------------------------------------------
// wrta_match
// Shared entry evaluation unit: wildcard key match for find, age check for
// expire. Decides whether the entry under test leaves the table.
// ----------------------------------------------------------------------------
module wrta_match (
  input  wrta_pkg::entry_t entry,
  input  logic             find_mode,
  input  logic             already_hit,
  input  logic [15:0]      service_key,
  input  logic [15:0]      subtype_key,
  input  logic [31:0]      request_key,
  input  logic [31:0]      now_seconds,
  input  logic [31:0]      max_age,
  output logic             drop
);

  logic        key_hit;
  logic [31:0] age;
  logic        aged;

  always_comb begin
    key_hit = ((service_key == 16'd0) || (entry.service == service_key)) &&
              ((subtype_key == 16'd0) || (entry.subtype == subtype_key)) &&
              ((request_key == 32'd0) || (entry.request == request_key));
    // a stamp in the future counts as age zero
    age  = (now_seconds >= entry.stamp) ? (now_seconds - entry.stamp) : 32'd0;
    aged = (age >= max_age);
    // find removes only the oldest match
    drop = find_mode ? (key_hit && !already_hit) : aged;
  end

endmodule
